>>> hw/rtl/lcs_pkg.sv
// Shared constants and types of the longest common subsequence length engine.
`default_nettype none

package lcs_pkg;

    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 24;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 11;

    localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROCESS_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END = 2'd2;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [LEN_W-1:0]  len_t;

endpackage : lcs_pkg

`default_nettype wire

>>> hw/rtl/lcs_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface lcs_in_if
    import lcs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    sym_t              symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink (input valid, input kind, input symbol, output ready);
endinterface : lcs_in_if

interface lcs_out_if
    import lcs_pkg::*;
;
    logic valid;
    logic ready;
    len_t lcs_length;
    logic overflow;

    modport source (output valid, output lcs_length, output overflow, input ready);
    modport sink (input valid, input lcs_length, input overflow, output ready);
endinterface : lcs_out_if

`default_nettype wire

>>> hw/rtl/lcs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : lcs_ram

`default_nettype wire

>>> hw/rtl/lcs_length_engine_core.sv
// Top level of the longest common subsequence length engine.
// A process-B item runs the row sweep, which reads, updates and writes one DP column
// per cycle. An end item moves its result through END_RD when the last DP column is
// read, then through END_OUT into the output register, later while the previous result
// still waits; one item at a time, ready only in idle.
// Reset clears the control state and the counters; the stores keep their contents,
// and the DP row reads as zero until the first B item of a pair has swept it.
`default_nettype none

module lcs_length_engine_core
    import lcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcs_in_if.sink      sym_ch,
    lcs_out_if.source   len_ch
);

    // The sequencer: IDLE takes items, SWEEP walks the DP row column by column,
    // END_RD fetches the last column, END_OUT hands the length to the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_END_RD,
        S_END_OUT
    } state_t;

    state_t state_reg, state_next;
    cnt_t   a_count_reg, a_count_next;
    logic   row_fresh_reg, row_fresh_next;
    logic   a_overflow_reg, a_overflow_next;
    sym_t   b_sym_reg, b_sym_next;
    cnt_t   issue_reg, issue_next;     // next column whose read is issued
    addr_t  col_reg, col_next;         // column whose read data is now back
    logic   col_vld_reg, col_vld_next;
    cnt_t   diag_reg, diag_next;       // old value of the previous column
    cnt_t   left_reg, left_next;       // new value of the previous column
    cnt_t   len_reg, len_next;
    logic   out_vld_reg, out_vld_next;
    len_t   out_len_reg, out_len_next;
    logic   out_ovf_reg, out_ovf_next;

    logic   accept;
    cnt_t   last_col;

    // Store ports.
    logic   a_wr_en;
    logic   a_rd_en;
    sym_t   a_rd_data;
    logic   dp_wr_en;
    cnt_t   dp_wr_data;
    logic   dp_rd_en;
    addr_t  dp_rd_addr;
    cnt_t   dp_rd_data;

    // Column datapath: the one shared compare/max/increment unit.
    cnt_t   up_val;
    cnt_t   col_val;

    assign accept   = sym_ch.valid && sym_ch.ready;
    assign last_col = a_count_reg - CNT_W'(1);

    assign up_val  = row_fresh_reg ? '0 : dp_rd_data;
    assign col_val = (a_rd_data == b_sym_reg) ? (diag_reg + CNT_W'(1))
                   : ((up_val > left_reg) ? up_val : left_reg);

    lcs_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (a_count_reg[ADDR_W-1:0]),
        .wr_data (sym_ch.symbol),
        .rd_en   (a_rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (a_rd_data)
    );

    lcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_LEN)
    ) u_dp_row (
        .clk     (clk),
        .wr_en   (dp_wr_en),
        .wr_addr (col_reg),
        .wr_data (dp_wr_data),
        .rd_en   (dp_rd_en),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        a_count_next    = a_count_reg;
        row_fresh_next  = row_fresh_reg;
        a_overflow_next = a_overflow_reg;
        b_sym_next      = b_sym_reg;
        issue_next      = issue_reg;
        col_next        = col_reg;
        col_vld_next    = 1'b0;
        diag_next       = diag_reg;
        left_next       = left_reg;
        len_next        = len_reg;
        out_vld_next    = out_vld_reg && !len_ch.ready;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;

        a_wr_en    = 1'b0;
        a_rd_en    = 1'b0;
        dp_wr_en   = 1'b0;
        dp_wr_data = col_val;
        dp_rd_en   = 1'b0;
        dp_rd_addr = issue_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (sym_ch.kind)
                        KIND_APPEND_A:
                        begin
                            // A symbols are taken only before the first B of a pair.
                            if (row_fresh_reg)
                            begin
                                if (a_count_reg < CNT_W'(MAX_LEN))
                                begin
                                    a_wr_en      = 1'b1;
                                    a_count_next = a_count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    a_overflow_next = 1'b1;
                                end
                            end
                        end
                        KIND_PROCESS_B:
                        begin
                            b_sym_next = sym_ch.symbol;
                            issue_next = '0;
                            diag_next  = '0;
                            left_next  = '0;
                            state_next = S_SWEEP;
                        end
                        KIND_END:
                        begin
                            if (!row_fresh_reg && (a_count_reg != '0))
                            begin
                                dp_rd_en   = 1'b1;
                                dp_rd_addr = last_col[ADDR_W-1:0];
                                state_next = S_END_RD;
                            end
                            else
                            begin
                                len_next   = '0;
                                state_next = S_END_OUT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // Issue the read of the next column while the previous one retires.
                if (issue_reg < a_count_reg)
                begin
                    a_rd_en      = 1'b1;
                    dp_rd_en     = 1'b1;
                    col_next     = issue_reg[ADDR_W-1:0];
                    col_vld_next = 1'b1;
                    issue_next   = issue_reg + CNT_W'(1);
                end
                if (col_vld_reg)
                begin
                    dp_wr_en  = 1'b1;
                    diag_next = up_val;
                    left_next = col_val;
                end
                if (!(issue_reg < a_count_reg) && !col_vld_reg)
                begin
                    row_fresh_next = 1'b0;
                    state_next     = S_IDLE;
                end
                else if (!(issue_reg < a_count_reg) && col_vld_reg)
                begin
                    row_fresh_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_END_RD:
            begin
                len_next   = dp_rd_data;
                state_next = S_END_OUT;
            end
            S_END_OUT:
            begin
                if (!out_vld_reg || len_ch.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_len_next    = LEN_W'(len_reg);
                    out_ovf_next    = a_overflow_reg;
                    a_count_next    = '0;
                    a_overflow_next = 1'b0;
                    row_fresh_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            a_count_reg    <= '0;
            row_fresh_reg  <= 1'b1;
            a_overflow_reg <= 1'b0;
            col_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
            b_sym_reg      <= '0;
            issue_reg      <= '0;
            col_reg        <= '0;
            diag_reg       <= '0;
            left_reg       <= '0;
            len_reg        <= '0;
            out_len_reg    <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            a_count_reg    <= a_count_next;
            row_fresh_reg  <= row_fresh_next;
            a_overflow_reg <= a_overflow_next;
            col_vld_reg    <= col_vld_next;
            out_vld_reg    <= out_vld_next;
            b_sym_reg      <= b_sym_next;
            issue_reg      <= issue_next;
            col_reg        <= col_next;
            diag_reg       <= diag_next;
            left_reg       <= left_next;
            len_reg        <= len_next;
            out_len_reg    <= out_len_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    // The result sits in its own register, so new items are taken while it waits.
    assign sym_ch.ready      = (state_reg == S_IDLE);
    assign len_ch.valid      = out_vld_reg;
    assign len_ch.lcs_length = out_len_reg;
    assign len_ch.overflow   = out_ovf_reg;

endmodule : lcs_length_engine_core

`default_nettype wire

>>> hw/rtl/lcs_length_engine_checker.sv
// Port-level assertions for the LCS length engine and their bind to the top level.
`default_nettype none

module lcs_length_engine_checker
    import lcs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [KIND_W-1:0] in_kind,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [LEN_W-1:0]  out_length,
    input wire logic              out_overflow
);

    // A B item always starts a row sweep, so the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_kind == KIND_PROCESS_B)) |=> !in_ready)
    else $error("input ready right after a B item");

    // An end item always goes through the result path before new items are taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_kind == KIND_END)) |=> !in_ready)
    else $error("input ready right after an end item");

    // A result length never exceeds the A store capacity, MAX_LEN.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_length <= LEN_W'(MAX_LEN)))
    else $error("result length beyond capacity");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_length)
                                       && $stable(out_overflow)))
    else $error("stalled result changed");

endmodule : lcs_length_engine_checker

bind lcs_length_engine_core lcs_length_engine_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sym_ch.valid),
    .in_ready     (sym_ch.ready),
    .in_kind      (sym_ch.kind),
    .out_valid    (len_ch.valid),
    .out_ready    (len_ch.ready),
    .out_length   (len_ch.lcs_length),
    .out_overflow (len_ch.overflow)
);

`default_nettype wire
